### rtl/fomm_pkg.sv
// Package for the field-oriented mecanum mixer: beat types, cell data,
// tangent and wheel coefficient tables. No dependencies.
package fomm_pkg;

    localparam int FRAC_BITS      = 15;
    localparam int QUADRANT_STEPS = 90;
    localparam int OCTANT         = 45;
    localparam int DEG_TURN       = 360;
    localparam int HALF_TURN      = 180;
    localparam int THREE_QUARTER  = 270;
    localparam longint TAN_UNIT   = 64'd1000000000;
    localparam logic [14:0] DEADBAND_RESET = 15'd1638;

    // Chain of cells: sqrt needs one cell per root bit, the others ride along
    localparam int SQRT_STEPS   = 16;
    localparam int MOD_STEPS    = 11;
    localparam int SEARCH_STEPS = 6;
    localparam int CHAIN_LEN    = SQRT_STEPS;
    localparam int STEP_W       = $clog2(CHAIN_LEN);
    localparam logic [15:0] SIG_ONE = 16'd32768;

    typedef struct packed {
        logic signed [15:0] joy_x;
        logic signed [15:0] joy_y;
        logic signed [15:0] turn_rate;
        logic signed [23:0] heading_raw;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] front_left_drive;
        logic signed [15:0] front_right_drive;
        logic signed [15:0] back_left_drive;
        logic signed [15:0] back_right_drive;
    } result_t;

    // Work in flight inside one cell
    typedef struct packed {
        logic [31:0]        rem;
        logic [15:0]        root;
        logic [19:0]        gyro;
        logic               gyro_neg;
        logic [5:0]         k;
        logic               exact;
        logic [45:0]        nu;
        logic [15:0]        den;
        logic signed [15:0] turn;
        logic               x_zero;
        logic               y_zero;
        logic               x_neg;
        logic               y_neg;
        logic               swap;
    } cell_t;

    typedef logic [FRAC_BITS:0] coef_tab_t [0:OCTANT];

    // tan(k deg) in units of 1e-9
    function automatic logic [29:0] tan_lut(input logic [5:0] k);
        logic [29:0] v;
        case (k)
            6'd0:  v = 30'd0;          6'd1:  v = 30'd17455065;
            6'd2:  v = 30'd34920770;   6'd3:  v = 30'd52407779;
            6'd4:  v = 30'd69926812;   6'd5:  v = 30'd87488664;
            6'd6:  v = 30'd105104235;  6'd7:  v = 30'd122784561;
            6'd8:  v = 30'd140540835;  6'd9:  v = 30'd158384440;
            6'd10: v = 30'd176326981;  6'd11: v = 30'd194380309;
            6'd12: v = 30'd212556562;  6'd13: v = 30'd230868191;
            6'd14: v = 30'd249328003;  6'd15: v = 30'd267949192;
            6'd16: v = 30'd286745386;  6'd17: v = 30'd305730681;
            6'd18: v = 30'd324919696;  6'd19: v = 30'd344327613;
            6'd20: v = 30'd363970234;  6'd21: v = 30'd383864035;
            6'd22: v = 30'd404026226;  6'd23: v = 30'd424474816;
            6'd24: v = 30'd445228685;  6'd25: v = 30'd466307658;
            6'd26: v = 30'd487732589;  6'd27: v = 30'd509525449;
            6'd28: v = 30'd531709432;  6'd29: v = 30'd554309051;
            6'd30: v = 30'd577350269;  6'd31: v = 30'd600860619;
            6'd32: v = 30'd624869352;  6'd33: v = 30'd649407593;
            6'd34: v = 30'd674508517;  6'd35: v = 30'd700207538;
            6'd36: v = 30'd726542528;  6'd37: v = 30'd753554050;
            6'd38: v = 30'd781285627;  6'd39: v = 30'd809784033;
            6'd40: v = 30'd839099631;  6'd41: v = 30'd869286738;
            6'd42: v = 30'd900404044;  6'd43: v = 30'd932515086;
            6'd44: v = 30'd965688775;  6'd45: v = 30'd1000000000;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Wheel coefficients, tangent rounded half up to FRAC_BITS fraction bits
    function automatic coef_tab_t build_coef();
        coef_tab_t tab;
        longint    v;
        for (int i = 0; i <= OCTANT; i++)
        begin
            v = ((longint'(tan_lut(6'(i))) << FRAC_BITS) + TAN_UNIT / 2) / TAN_UNIT;
            tab[i] = (FRAC_BITS + 1)'(v);
        end
        return tab;
    endfunction

    localparam coef_tab_t COEF_TAB = build_coef();

endpackage

### rtl/fomm_front.sv
// Entry stage: deadband, squares, angle search operands, gyro magnitude.
// Depends on fomm_pkg.
module fomm_front
    import fomm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cmd_t        cmd,
    input  logic [14:0] deadband_level,
    output logic        out_valid,
    output cell_t       out_data
);

    logic [16:0] ax, ay, at;
    logic        xz, yz, tz;
    logic [15:0] a, b, num;
    logic [23:0] habs;
    logic        valid_reg;
    cell_t       data_reg, data_next;

    // Absolute values and deadband
    always_comb
    begin
        ax = cmd.joy_x[15] ? 17'(-{cmd.joy_x[15], cmd.joy_x}) : {1'b0, cmd.joy_x};
        ay = cmd.joy_y[15] ? 17'(-{cmd.joy_y[15], cmd.joy_y}) : {1'b0, cmd.joy_y};
        at = cmd.turn_rate[15] ? 17'(-{cmd.turn_rate[15], cmd.turn_rate})
                               : {1'b0, cmd.turn_rate};
        xz = ax <= {2'b0, deadband_level};
        yz = ay <= {2'b0, deadband_level};
        tz = at <= {2'b0, deadband_level};
        a  = xz ? 16'd0 : ax[15:0];
        b  = yz ? 16'd0 : ay[15:0];
        habs = cmd.heading_raw[23] ? 24'(-cmd.heading_raw) : cmd.heading_raw;
        num  = (a > b) ? b : a;
    end

    // Operands for the cell chain
    always_comb
    begin
        data_next.rem      = 32'(32'(a) * 32'(a) + 32'(b) * 32'(b));
        data_next.root     = 16'd0;
        data_next.gyro     = habs[23:4];
        data_next.gyro_neg = cmd.heading_raw[23];
        data_next.k        = 6'd0;
        data_next.exact    = 1'b0;
        data_next.nu       = 46'(46'(num) * 46'(TAN_UNIT));
        data_next.den      = (a > b) ? a : b;
        data_next.turn     = tz ? 16'sd0 : cmd.turn_rate;
        data_next.x_zero   = xz;
        data_next.y_zero   = yz;
        data_next.x_neg    = cmd.joy_x[15];
        data_next.y_neg    = cmd.joy_y[15];
        data_next.swap     = a > b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/fomm_cell.sv
// One cell of the chain: a root bit, a mod-360 step and an angle search step.
// Depends on fomm_pkg.
module fomm_cell
    import fomm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  logic              in_valid,
    input  cell_t             in_data,
    output logic              out_valid,
    output cell_t             out_data
);

    logic [STEP_W-1:0] rb;
    logic [33:0]       delta;
    logic [3:0]        ms;
    logic [19:0]       mv;
    logic [5:0]        cand, sel;
    logic [45:0]       prod;
    logic              valid_reg;
    cell_t             data_reg, data_next;

    always_comb
    begin
        data_next = in_data;

        // Square root: try the next root bit
        rb    = STEP_W'(CHAIN_LEN - 1) - step;
        delta = (34'(in_data.root) << (rb + 1'b1)) + (34'd1 << (5'(rb) << 1));
        if ({2'b0, in_data.rem} >= delta)
        begin
            data_next.rem  = 32'({2'b0, in_data.rem} - delta);
            data_next.root = in_data.root | (16'd1 << rb);
        end

        // Gyro degrees mod 360, one shifted subtract
        ms = 4'(MOD_STEPS - 1) - 4'(step);
        mv = 20'(DEG_TURN) << ms;
        if ((step < STEP_W'(MOD_STEPS)) && (in_data.gyro >= mv))
            data_next.gyro = in_data.gyro - mv;

        // Tangent table search, then the exact-hit check
        cand = in_data.k | (6'd1 << (3'(SEARCH_STEPS - 1) - 3'(step)));
        sel  = (step < STEP_W'(SEARCH_STEPS)) ? cand : in_data.k;
        prod = 46'(in_data.den) * 46'(tan_lut(sel));
        if ((step < STEP_W'(SEARCH_STEPS)) && (cand <= 6'(OCTANT)) && (in_data.nu >= prod))
            data_next.k = cand;
        if (step == STEP_W'(SEARCH_STEPS))
            data_next.exact = in_data.nu == prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/fomm_back.sv
// Exit stages: field angle, quadrant, wheel coefficient, product, turn mix.
// Depends on fomm_pkg.
module fomm_back
    import fomm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  cell_t   in_data,
    output logic    done,
    output result_t result
);

    logic [6:0]  tq;
    logic [8:0]  comp, gdeg, fa, th_base;
    logic signed [9:0] diff;
    logic [1:0]  quad_next;
    logic [6:0]  th;
    logic signed [7:0] d;
    logic [5:0]  idx;

    logic                 b1_valid_reg, b2_valid_reg, done_reg;
    logic [15:0]          mag_reg, mag_next;
    logic [FRAC_BITS:0]   coef_reg;
    logic                 dneg_reg;
    logic [1:0]           q1_reg, q2_reg;
    logic signed [15:0]   t1_reg, t2_reg;
    logic [31:0]          prod;
    logic [15:0]          pmag;
    logic signed [16:0]   p_reg, p_next, m_reg;
    logic signed [16:0]   fl, fr, bl, br;
    result_t              result_reg, result_next;

    // Wheel value plus half the turn, saturated, halved toward zero
    function automatic logic signed [15:0] mix(input logic signed [16:0] v,
                                               input logic signed [15:0] t);
        logic signed [18:0] s;
        logic signed [18:0] h;
        s = 19'(v) * 19'sd2 + 19'(t);
        if (s > 19'sd65534)
            s = 19'sd65534;
        if (s < -19'sd65534)
            s = -19'sd65534;
        h = (s < 0) ? -((-s) >>> 1) : (s >>> 1);
        return h[15:0];
    endfunction

    // Compass angle, field angle, quadrant and table index
    always_comb
    begin
        if (!in_data.swap)
            tq = 7'(in_data.k);
        else if (in_data.exact)
            tq = 7'(QUADRANT_STEPS) - 7'(in_data.k);
        else
            tq = 7'(QUADRANT_STEPS - 1) - 7'(in_data.k);

        if (in_data.x_zero)
            comp = (in_data.y_zero || in_data.y_neg) ? 9'd0 : 9'(HALF_TURN);
        else if (in_data.y_zero)
            comp = in_data.x_neg ? 9'(THREE_QUARTER) : 9'(QUADRANT_STEPS);
        else if (!in_data.x_neg && in_data.y_neg)
            comp = 9'(tq);
        else if (!in_data.x_neg)
            comp = in_data.exact ? 9'(HALF_TURN) - 9'(tq) : 9'(HALF_TURN - 1) - 9'(tq);
        else if (in_data.y_neg)
            comp = in_data.exact ? 9'(DEG_TURN) - 9'(tq) : 9'(DEG_TURN - 1) - 9'(tq);
        else
            comp = 9'(HALF_TURN) + 9'(tq);

        gdeg = (in_data.gyro_neg && (in_data.gyro != 20'd0))
             ? 9'(DEG_TURN) - 9'(in_data.gyro) : 9'(in_data.gyro);
        diff = 10'(comp) - 10'(gdeg);
        fa   = (diff < 0) ? 9'(diff + 10'sd360) : 9'(diff);

        if (fa >= 9'(THREE_QUARTER))
        begin
            quad_next = 2'd3;
            th_base   = 9'(THREE_QUARTER);
        end
        else if (fa >= 9'(HALF_TURN))
        begin
            quad_next = 2'd2;
            th_base   = 9'(HALF_TURN);
        end
        else if (fa >= 9'(QUADRANT_STEPS))
        begin
            quad_next = 2'd1;
            th_base   = 9'(QUADRANT_STEPS);
        end
        else
        begin
            quad_next = 2'd0;
            th_base   = 9'd0;
        end
        th  = 7'(fa - th_base);
        d   = 8'sd45 - 8'(th);
        idx = (d < 0) ? 6'(-d) : 6'(d);
        mag_next = (in_data.root > SIG_ONE) ? SIG_ONE : in_data.root;
    end

    // Product rounded half away from zero, sign applied after
    always_comb
    begin
        prod   = 32'(mag_reg) * 32'(coef_reg);
        pmag   = 16'((prod + (32'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        p_next = dneg_reg ? -17'(pmag) : 17'(pmag);
    end

    // Quadrant routing to the wheel pairs
    always_comb
    begin
        case (q2_reg)
            2'd0:
            begin
                fl = m_reg;  br = -m_reg; fr = -p_reg; bl = p_reg;
            end
            2'd1:
            begin
                fr = m_reg;  bl = -m_reg; br = -p_reg; fl = p_reg;
            end
            2'd2:
            begin
                fl = -m_reg; br = m_reg;  fr = p_reg;  bl = -p_reg;
            end
            default:
            begin
                fr = -m_reg; bl = m_reg;  fl = -p_reg; br = p_reg;
            end
        endcase
        result_next.front_left_drive  = mix(fl, t2_reg);
        result_next.front_right_drive = mix(fr, t2_reg);
        result_next.back_left_drive   = mix(bl, t2_reg);
        result_next.back_right_drive  = mix(br, t2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            done_reg     <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        coef_reg   <= COEF_TAB[idx];
        dneg_reg   <= d < 0;
        q1_reg     <= quad_next;
        t1_reg     <= in_data.turn;
        p_reg      <= p_next;
        m_reg      <= 17'(mag_reg);
        q2_reg     <= q1_reg;
        t2_reg     <= t1_reg;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/field_oriented_mecanum_mixer.sv
// Field-oriented mecanum mixer top level: front stage, chain of cells, exit stages.
// Depends on fomm_pkg, fomm_front, fomm_cell, fomm_back.
// One entry stage, 16 chain cells set by the square root bit count, 3 exit stages.
// Throughput: one command per cycle; busy stays low and results cannot be stalled.
// Reset: all beats in flight are dropped; deadband_level returns to 1638.
module field_oriented_mecanum_mixer
    import fomm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    logic [14:0] deadband_reg;
    logic        chain_valid [0:CHAIN_LEN];
    cell_t       chain_data  [0:CHAIN_LEN];

    // Deadband register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadband_reg <= DEADBAND_RESET;
        else if (cfg_valid && cfg_ready)
            deadband_reg <= cfg_data;
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    fomm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .cmd            (cmd),
        .deadband_level (deadband_reg),
        .out_valid      (chain_valid[0]),
        .out_data       (chain_data[0])
    );

    // Chain of cells
    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_cell
        fomm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    fomm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CHAIN_LEN]),
        .in_data  (chain_data[CHAIN_LEN]),
        .done     (done),
        .result   (result)
    );

endmodule

### rtl/fomm_checker.sv
// Port checker for the mixer, bound to the top level.
// Depends on fomm_pkg and field_oriented_mecanum_mixer.
module fomm_checker
    import fomm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input result_t     result,
    input logic        cfg_ready
);

    // Every result beat traces back to an earlier command
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 20))
        else $error("result beat without a command");

    // Saturation keeps every wheel off the most negative code
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.front_left_drive != 16'sh8000) &&
                 (result.front_right_drive != 16'sh8000) &&
                 (result.back_left_drive != 16'sh8000) &&
                 (result.back_right_drive != 16'sh8000))
        else $error("wheel output out of range");

    // Fully pipelined: never refuses a command or a register write
    a_always_open: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("block refused a beat");

endmodule

bind field_oriented_mecanum_mixer fomm_checker u_fomm_checker (.*);
